FILE: src/imhq_pkg.sv
// ---------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed min-heap queue.
// ---------------------------------------------------------------------------
package imhq_pkg;

	localparam int CAPACITY_DEF      = 256;
	localparam int KEY_BITS_DEF      = 8;
	localparam int PRIORITY_BITS_DEF = 32;

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POPLAST,
		S_UPD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_PLACE,
		S_TOP_RD,
		S_OUT
	} fsm_t;

endpackage

FILE: src/imhq_ram.sv
// ---------------------------------------------------------------------------
// imhq_ram
// Generic single-write, dual-read RAM with registered read data.
// ---------------------------------------------------------------------------
module imhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: src/indexed_min_heap_queue.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of (key, priority) pairs with push, pop and update.
// ---------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, command, key, priority_req  | into block
//  out     | out_valid, out_stall, status, top_key,          | out of block
//          | top_priority, is_empty, entry_total             |
//
// An accepted push goes through decode, then a slot memory read and a compare
// for every heap level that the sift visits, then place, root read, result
// load and return to idle. A pop or an update adds a step to fetch the entry
// it moves; a rejected command or a pop of the last entry goes from decode
// straight to the root read. Reset clears occupancy, control state and the
// key-present flags at once; the slot and key tables need no clearing. The
// result sits in an output register, and no new item is taken while that
// result is held there by a stall, nor before the last item is through.
module indexed_min_heap_queue
	import imhq_pkg::*;
#(
	parameter int CAPACITY      = CAPACITY_DEF,
	parameter int KEY_BITS      = KEY_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      command,
	input  logic [KEY_BITS-1:0]             key,
	input  logic signed [PRIORITY_BITS-1:0] priority_req,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic [KEY_BITS-1:0]             top_key,
	output logic signed [PRIORITY_BITS-1:0] top_priority,
	output logic                            is_empty,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_total
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY+1);
	localparam int NKEY = 1 << KEY_BITS;
	localparam int SW   = KEY_BITS + PRIORITY_BITS;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	// Slot memory holds {key, biased priority}; biasing flips the sign bit so
	// an unsigned compare orders priorities.
	logic          s_we;
	logic [AW-1:0] s_wa, s_ra, s_rb;
	logic [SW-1:0] s_wd, s_da, s_db;
	logic          k_we;
	logic [KEY_BITS-1:0] k_wa, k_ra;
	logic [AW-1:0] k_wd, k_da, k_db;

	imhq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot (
		.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.raddr_a(s_ra), .rdata_a(s_da), .raddr_b(s_rb), .rdata_b(s_db));
	imhq_ram #(.WIDTH(AW), .DEPTH(NKEY)) u_kslot (
		.clk, .we(k_we), .waddr(k_wa), .wdata(k_wd),
		.raddr_a(k_ra), .rdata_a(k_da), .raddr_b(k_ra), .rdata_b(k_db));

	fsm_t state_q, state_d;
	logic [NKEY-1:0] present_q;
	logic [CW-1:0]   occ_q;
	logic [1:0]          cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [CW-1:0]   idx_q;
	logic [2:0]      st_q;

	logic [PRIORITY_BITS-1:0] pri_b;
	assign pri_b = {~priority_req[PRIORITY_BITS-1], priority_req[PRIORITY_BITS-2+1-1:0]};

	logic [CW-1:0] par, lc, rc;
	assign par = (idx_q - CW'(1)) >> 1;
	assign lc  = CW'({idx_q, 1'b1});
	assign rc  = lc + CW'(1);

	logic [PRIORITY_BITS-1:0] pa, pb;
	assign pa = s_da[PRIORITY_BITS-1:0];
	assign pb = s_db[PRIORITY_BITS-1:0];
	logic l_ok, r_ok;
	assign l_ok = ({1'b0, idx_q} << 1) + (CW+1)'(1) < {1'b0, occ_q};
	assign r_ok = ({1'b0, idx_q} << 1) + (CW+1)'(2) < {1'b0, occ_q};

	// Idle is the only state that takes an item, and only while no result
	// waits behind a stall.
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			present_q <= '0;
			occ_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (state_q == S_DECODE) begin
				if (cmd_q == CMD_PUSH && !present_q[key_q] && occ_q < CAP) begin
					present_q[key_q] <= 1'b1;
					occ_q <= occ_q + CW'(1);
				end else if (cmd_q == CMD_POP && occ_q != '0) begin
					present_q[s_da[SW-1:PRIORITY_BITS]] <= 1'b0;
					occ_q <= occ_q - CW'(1);
				end
			end
			if (state_q == S_OUT) begin
				out_valid <= 1'b1;
			end
		end
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q <= command;
					key_q <= key;
					pri_q <= pri_b;
				end
			end
			S_DECODE: begin
				st_q <= ST_OK;
				case (cmd_q)
					CMD_PUSH: begin
						if (present_q[key_q]) st_q <= ST_PRESENT;
						else if (occ_q >= CAP) st_q <= ST_FULL;
						idx_q <= occ_q;
					end
					CMD_POP: begin
						if (occ_q == '0) st_q <= ST_EMPTY;
						idx_q <= '0;
					end
					CMD_UPDATE: begin
						if (!present_q[key_q] || CW'(k_da) >= occ_q) st_q <= ST_ABSENT;
						idx_q <= CW'(k_da);
					end
					default: ;
				endcase
			end
			S_POPLAST: begin
				key_q <= s_da[SW-1:PRIORITY_BITS];
				pri_q <= pa;
			end
			S_UP_CMP: begin
				if (idx_q != '0 && !(pa < pri_q)) idx_q <= par;
			end
			S_DN_CMP: begin
				if (l_ok && pa < pri_q && !(r_ok && pb < pa)) idx_q <= lc;
				else if (r_ok && pb < pri_q) idx_q <= rc;
			end
			S_OUT: begin
				status <= st_q;
				if (occ_q == '0) begin
					top_key <= '0;
					top_priority <= '0;
					is_empty <= 1'b1;
				end else begin
					top_key <= s_da[SW-1:PRIORITY_BITS];
					top_priority <= {~pa[PRIORITY_BITS-1], pa[PRIORITY_BITS-2+1-1:0]};
					is_empty <= 1'b0;
				end
				entry_total <= occ_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		s_we = 1'b0; s_wa = '0; s_wd = {key_q, pri_q};
		s_ra = '0; s_rb = '0;
		k_we = 1'b0; k_wa = key_q; k_wd = '0; k_ra = key_q;
		case (state_q)
			S_IDLE: begin
				k_ra = key;
				if (in_valid && !(out_valid && out_stall)) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_TOP_RD;
				case (cmd_q)
					CMD_PUSH: begin
						if (!present_q[key_q] && occ_q < CAP) state_d = S_UP_RD;
					end
					CMD_POP: begin
						s_ra = AW'(occ_q - CW'(1));
						if (occ_q > CW'(1)) state_d = S_POPLAST;
					end
					CMD_UPDATE: begin
						s_ra = AW'(k_da);
						if (present_q[key_q] && CW'(k_da) < occ_q) state_d = S_UPD;
					end
					default: ;
				endcase
			end
			S_POPLAST: state_d = S_DN_RD;
			S_UPD: begin
				if (pri_q < pa) state_d = S_UP_RD;
				else if (pa < pri_q) state_d = S_DN_RD;
				else state_d = S_TOP_RD;
			end
			S_UP_RD: begin
				s_ra = AW'(par);
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (idx_q == '0 || pa < pri_q) begin
					state_d = S_PLACE;
				end else begin
					s_we = 1'b1; s_wa = AW'(idx_q); s_wd = s_da;
					k_we = 1'b1; k_wa = s_da[SW-1:PRIORITY_BITS]; k_wd = AW'(idx_q);
					state_d = S_UP_RD;
				end
			end
			S_DN_RD: begin
				s_ra = AW'(lc); s_rb = AW'(rc);
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (l_ok && pa < pri_q && !(r_ok && pb < pa)) begin
					s_we = 1'b1; s_wa = AW'(idx_q); s_wd = s_da;
					k_we = 1'b1; k_wa = s_da[SW-1:PRIORITY_BITS]; k_wd = AW'(idx_q);
					state_d = S_DN_RD;
				end else if (r_ok && pb < pri_q) begin
					s_we = 1'b1; s_wa = AW'(idx_q); s_wd = s_db;
					k_we = 1'b1; k_wa = s_db[SW-1:PRIORITY_BITS]; k_wd = AW'(idx_q);
					state_d = S_DN_RD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				s_we = 1'b1; s_wa = AW'(idx_q);
				k_we = 1'b1; k_wd = AW'(idx_q);
				state_d = S_TOP_RD;
			end
			S_TOP_RD: begin
				s_ra = '0;
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Results get presented, occupancy stays within CAP and a stall holds status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CAP)
		else $error("occupancy above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(status))
		else $error("stalled result changed");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed min-heap queue: a directed table of
// commands followed by random push/pop/update traffic, every result checked
// against a behavioral heap model kept in the bench.
// ---------------------------------------------------------------------------
module testbench;
	import imhq_pkg::*;

	localparam int CAP = 256;

	// Result fields as the block reports them.
	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         top_key;
		logic signed [31:0] top_priority;
		logic               is_empty;
		logic [8:0]         entry_total;
	} heap_result_t;

	// One row of the directed table. A row with check_lit set also carries a
	// literal expectation that is compared in addition to the model.
	typedef struct {
		logic [1:0]         command;
		logic [7:0]         key;
		logic signed [31:0] priority_req;
		bit                 check_lit;
		logic [2:0]         lit_status;
		logic [8:0]         lit_total;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         command = CMD_PUSH;
	logic [7:0]         key = '0;
	logic signed [31:0] priority_req = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic [7:0]         top_key;
	logic signed [31:0] top_priority;
	logic               is_empty;
	logic [8:0]         entry_total;

	always #4 clk = ~clk;

	indexed_min_heap_queue u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .key(key), .priority_req(priority_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .top_key(top_key), .top_priority(top_priority),
		.is_empty(is_empty), .entry_total(entry_total)
	);

	// -----------------------------------------------------------------------
	// Heap model. Priorities are compared as signed values, which is the same
	// order as the biased unsigned compare the block performs.
	// -----------------------------------------------------------------------
	logic [7:0]         hp_key [CAP];
	logic signed [31:0] hp_pri [CAP];
	int unsigned        where_key [256];
	bit                 held [256];
	int unsigned        held_count;

	heap_result_t       pending_results [$];
	int                 errors = 0;
	int                 results_seen = 0;
	int                 status_hits [5];

	// Sift-up walks past parents that are equal or larger.
	function automatic void sift_toward_root(int unsigned idx, logic [7:0] k,
			logic signed [31:0] p);
		int unsigned par;
		while (idx > 0) begin
			par = (idx - 1) / 2;
			if (hp_pri[par] < p) break;
			hp_key[idx] = hp_key[par];
			hp_pri[idx] = hp_pri[par];
			where_key[hp_key[idx]] = idx;
			idx = par;
		end
		hp_key[idx] = k;
		hp_pri[idx] = p;
		where_key[k] = idx;
	endfunction

	// Sift-down moves only past a strictly smaller child; left wins ties.
	function automatic void sift_toward_leaf(int unsigned idx, logic [7:0] k,
			logic signed [31:0] p);
		int unsigned l, r, best;
		logic signed [31:0] bp;
		forever begin
			l = 2 * idx + 1;
			r = 2 * idx + 2;
			best = idx;
			bp = p;
			if (l < held_count && hp_pri[l] < bp) begin
				best = l;
				bp = hp_pri[l];
			end
			if (r < held_count && hp_pri[r] < bp) best = r;
			if (best == idx) break;
			hp_key[idx] = hp_key[best];
			hp_pri[idx] = hp_pri[best];
			where_key[hp_key[idx]] = idx;
			idx = best;
		end
		hp_key[idx] = k;
		hp_pri[idx] = p;
		where_key[k] = idx;
	endfunction

	function automatic heap_result_t apply_command(logic [1:0] c, logic [7:0] k,
			logic signed [31:0] p);
		heap_result_t res;
		int unsigned idx;
		res.status = ST_OK;
		case (c)
			CMD_PUSH: begin
				if (held[k]) res.status = ST_PRESENT;
				else if (held_count >= CAP) res.status = ST_FULL;
				else begin
					held[k] = 1'b1;
					held_count++;
					sift_toward_root(held_count - 1, k, p);
				end
			end
			CMD_POP: begin
				if (held_count == 0) res.status = ST_EMPTY;
				else begin
					held[hp_key[0]] = 1'b0;
					held_count--;
					if (held_count > 0)
						sift_toward_leaf(0, hp_key[held_count], hp_pri[held_count]);
				end
			end
			CMD_UPDATE: begin
				if (!held[k] || where_key[k] >= held_count) res.status = ST_ABSENT;
				else begin
					idx = where_key[k];
					if (p < hp_pri[idx]) sift_toward_root(idx, k, p);
					else if (hp_pri[idx] < p) sift_toward_leaf(idx, k, p);
				end
			end
			default: ;	// the spare command code is ignored
		endcase
		res.is_empty     = (held_count == 0);
		res.top_key      = res.is_empty ? 8'd0 : hp_key[0];
		res.top_priority = res.is_empty ? 32'sd0 : hp_pri[0];
		res.entry_total  = held_count[8:0];
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Input driver. send_item offers one item and waits until it is taken;
	// the model is advanced at acceptance so expectations line up in order.
	// Valid stays high after acceptance, so the next call either offers its
	// item at once or drops valid for its idle cycles.
	// -----------------------------------------------------------------------
	int  idle_pct_in = 22;
	int  idle_pct_out = 22;
	bit  hold_output = 1'b0;
	int  accepted = 0;
	bit  stim_done = 1'b0;

	task automatic send_item(logic [1:0] c, logic [7:0] k, logic signed [31:0] p);
		while ($urandom_range(99) < idle_pct_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= c;
		key          <= k;
		priority_req <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(apply_command(c, k, p));
		accepted++;
	endtask

	// Keys come mostly from a small pool so duplicates and absent keys are
	// common; priorities are drawn narrow for ties, with full-range values too.
	function automatic logic signed [31:0] pick_priority();
		case ($urandom_range(3))
			0:       return $signed($urandom());
			1:       return $signed($urandom_range(7)) - 32'sd4;
			2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(200));
		endcase
	endfunction

	function automatic logic [7:0] pick_key();
		return $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(40));
	endfunction

	stim_row_t directed [] = '{
		'{CMD_POP,    8'd0,   32'sd0,          1, ST_EMPTY,   9'd0},
		'{CMD_UPDATE, 8'd5,   32'sd1,          1, ST_ABSENT,  9'd0},
		'{2'd3,       8'hff,  32'sd9,          1, ST_OK,      9'd0},
		'{CMD_PUSH,   8'd0,   32'sh7fffffff,   1, ST_OK,      9'd1},
		'{CMD_PUSH,   8'd0,   32'sd3,          1, ST_PRESENT, 9'd1},
		'{CMD_PUSH,   8'hff,  32'sh80000000,   1, ST_OK,      9'd2},
		'{CMD_PUSH,   8'h55,  32'sh80000000,   0, ST_OK,      9'd0},
		'{CMD_PUSH,   8'haa,  -32'sd1,         0, ST_OK,      9'd0},
		'{CMD_PUSH,   8'd7,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_PUSH,   8'd8,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_UPDATE, 8'd7,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_UPDATE, 8'hff,  32'sh7fffffff,   0, ST_OK,      9'd0},
		'{CMD_UPDATE, 8'd0,   32'sh80000000,   0, ST_OK,      9'd0},
		'{CMD_UPDATE, 8'd9,   32'sd0,          1, ST_ABSENT,  9'd6},
		'{2'd3,       8'd0,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_POP,    8'hff,  -32'sd1,         0, ST_OK,      9'd0},
		'{CMD_POP,    8'd0,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_POP,    8'd0,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_POP,    8'd0,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_POP,    8'd0,   32'sd0,          0, ST_OK,      9'd0},
		'{CMD_POP,    8'd0,   32'sd0,          1, ST_OK,      9'd0},
		'{CMD_POP,    8'd0,   32'sd0,          1, ST_EMPTY,   9'd0}
	};
	int lit_index [$];	// accept index of rows carrying a literal
	int lit_row [$];

	// Drops valid and waits until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int mode;
		for (int i = 0; i < 256; i++) held[i] = 1'b0;
		held_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].check_lit) begin
				lit_index.push_back(accepted);
				lit_row.push_back(i);
			end
			send_item(directed[i].command, directed[i].key, directed[i].priority_req);
		end

		// Fill to capacity with distinct keys, then one push of a held key while
		// full: the duplicate check wins over the full check.
		wait_drained();
		idle_pct_in = 0;
		idle_pct_out = 0;
		for (int k = 0; k < 256; k++)
			send_item(CMD_PUSH, 8'(k), pick_priority());
		send_item(CMD_PUSH, 8'd3, 32'sd0);
		idle_pct_in = 22;
		idle_pct_out = 22;
		// Drain part of it so updates and pops work on a deep heap.
		for (int i = 0; i < 130; i++)
			send_item($urandom_range(2) == 0 ? CMD_UPDATE : CMD_POP,
				8'($urandom()), pick_priority());

		// Sender pauses until every result is back.
		wait_drained();

		// Receiver holds off for a long stretch while items keep coming.
		hold_output = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(2'($urandom_range(2)), pick_key(), pick_priority());
		wait_drained();

		// Random traffic, mixed so the heap grows and shrinks repeatedly.
		n = 0;
		while (n < 160) begin
			mode = (n / 40) % 2;	// grow, then shrink
			if (n >= 80 && n < 120) begin
				idle_pct_in = 0;	// stretch without idling
				idle_pct_out = 0;
			end else begin
				idle_pct_in = 22;
				idle_pct_out = 22;
			end
			case ($urandom_range(9))
				0, 1, 2, 3: send_item(mode ? CMD_POP : CMD_PUSH, pick_key(),
					pick_priority());
				4, 5:       send_item(CMD_UPDATE, pick_key(), pick_priority());
				6:          send_item(mode ? CMD_PUSH : CMD_POP, pick_key(),
					pick_priority());
				7:          send_item(2'($urandom()), 8'($urandom()), $signed($urandom()));
				default:    send_item(CMD_PUSH, pick_key(), pick_priority());
			endcase
			n++;
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Output side: random stalls, and one long hold-off on request.
	initial begin
		int held_cycles;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_stall <= 1'b1;
				held_cycles = 0;
				while (held_cycles < 300) begin
					@(posedge clk);
					held_cycles++;
				end
				hold_output = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct_out);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result checker, sampled at the accepting edge.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (lit_index.size() != 0 && lit_index[0] == results_seen) begin
					if (status !== directed[lit_row[0]].lit_status) begin
						$error("status (table row %0d): expected %0d, got %0d",
							lit_row[0], directed[lit_row[0]].lit_status, status);
						errors++;
					end
					if (entry_total !== directed[lit_row[0]].lit_total) begin
						$error("entry_total (table row %0d): expected %0d, got %0d",
							lit_row[0], directed[lit_row[0]].lit_total, entry_total);
						errors++;
					end
					void'(lit_index.pop_front());
					void'(lit_row.pop_front());
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (top_key !== want.top_key) begin
					$error("top_key: expected %0d, got %0d", want.top_key, top_key);
					errors++;
				end
				if (top_priority !== want.top_priority) begin
					$error("top_priority: expected %0d, got %0d",
						want.top_priority, top_priority);
					errors++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
					errors++;
				end
				if (entry_total !== want.entry_total) begin
					$error("entry_total: expected %0d, got %0d",
						want.entry_total, entry_total);
					errors++;
				end
				if (want.status <= ST_PRESENT) status_hits[want.status]++;
			end
			results_seen++;
		end
	end

	// -----------------------------------------------------------------------
	// Watchdog and end of run. The watchdog limit lies above the long hold-off
	// and the longest item, so a quiet stretch that reaches it means a stuck block.
	// -----------------------------------------------------------------------
	initial begin
		int quiet;
		int tail;
		quiet = 0;
		tail = 0;
		while (!(stim_done && pending_results.size() == 0 && tail >= 60)) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
			if (stim_done && pending_results.size() == 0) tail++;
			if (quiet >= 2000) begin
				$display("watchdog: no item moved for %0d cycles", quiet);
				$display("testbench failed");
				$finish;
			end
		end
		if (pending_results.size() != 0) errors++;
		$display("covered %0d commands, %0d results; ok %0d full %0d empty %0d",
			accepted, results_seen, status_hits[0], status_hits[1], status_hits[2]);
		$display("absent-key %0d, duplicate-key %0d, with fill to capacity and a long stall",
			status_hits[3], status_hits[4]);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
